@@ rtl/sic_pkg.sv @@
// Shared types, command codes and register indexes for the safety interlock controller.
package sic_pkg;

  // Widths of the configuration port.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 18;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_GAS_LIMIT         = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LIGHT_LIMIT       = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_POWER_LIMIT       = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CURRENT_LIMIT     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_RELAY_ACTIVE_HIGH = 3'd4;

  // Register reset values.
  localparam logic [11:0] GAS_LIMIT_RST     = 12'd250;
  localparam logic [11:0] LIGHT_LIMIT_RST   = 12'd2000;
  localparam logic [17:0] POWER_LIMIT_RST   = 18'd5000;
  localparam logic [16:0] CURRENT_LIMIT_RST = 17'd2000;

  // Operation codes.
  localparam logic OP_SAMPLE  = 1'b0;
  localparam logic OP_COMMAND = 1'b1;

  // Command codes; anything above CMD_RESET_ALARM is ignored.
  localparam logic [3:0] CMD_AUTO        = 4'd0;
  localparam logic [3:0] CMD_MANUAL      = 4'd1;
  localparam logic [3:0] CMD_R1_ON       = 4'd2;
  localparam logic [3:0] CMD_R1_OFF      = 4'd3;
  localparam logic [3:0] CMD_R2_ON       = 4'd4;
  localparam logic [3:0] CMD_R2_OFF      = 4'd5;
  localparam logic [3:0] CMD_BUZZER_OFF  = 4'd6;
  localparam logic [3:0] CMD_RESET_ALARM = 4'd7;

  // Alarm codes.
  localparam logic [1:0] ALARM_NONE     = 2'd0;
  localparam logic [1:0] ALARM_GAS      = 2'd1;
  localparam logic [1:0] ALARM_OVERLOAD = 2'd2;
  localparam logic [1:0] ALARM_SENSOR   = 2'd3;

  // Configuration register file contents.
  typedef struct packed {
    logic [11:0] gas_limit;
    logic [11:0] light_limit;
    logic [17:0] power_limit;
    logic [16:0] current_limit;
    logic        relay_active_high;
  } cfg_t;

  // One input request.
  typedef struct packed {
    logic        operation;
    logic [3:0]  command;
    logic        climate_ok;
    logic        meter_ok;
    logic [11:0] gas_level;
    logic [11:0] light_level;
    logic [16:0] current_ma;
    logic [17:0] power_dw;
  } item_t;

  // Controller state carried from one request to the next.
  typedef struct packed {
    logic        mode_auto;
    logic [1:0]  alarm_latch;
    logic        unsafe_flag;
    logic        load_relay;
    logic        lamp_relay;
    logic        buzzer;
    logic [17:0] held_power;
    logic [16:0] held_current;
  } state_t;

  // One result request.
  typedef struct packed {
    logic       load_on;
    logic       lamp_on;
    logic       load_pin;
    logic       lamp_pin;
    logic       buzzer_on;
    logic [1:0] alarm_code;
    logic       auto_mode;
    logic       danger;
  } result_t;

endpackage

@@ rtl/sic_cfg_regs.sv @@
// Configuration register file of the safety interlock controller.
module sic_cfg_regs import sic_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  logic [CFG_INDEX_W-1:0] wr_index,
  input  logic [CFG_DATA_W-1:0]  wr_data,
  output cfg_t                   cfg
);

  // Write the addressed register; indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gas_limit         <= GAS_LIMIT_RST;
      cfg.light_limit       <= LIGHT_LIMIT_RST;
      cfg.power_limit       <= POWER_LIMIT_RST;
      cfg.current_limit     <= CURRENT_LIMIT_RST;
      cfg.relay_active_high <= 1'b0;
    end else if (wr_en) begin
      case (wr_index)
        REG_GAS_LIMIT:         cfg.gas_limit         <= wr_data[11:0];
        REG_LIGHT_LIMIT:       cfg.light_limit       <= wr_data[11:0];
        REG_POWER_LIMIT:       cfg.power_limit       <= wr_data[17:0];
        REG_CURRENT_LIMIT:     cfg.current_limit     <= wr_data[16:0];
        REG_RELAY_ACTIVE_HIGH: cfg.relay_active_high <= wr_data[0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/sic_step.sv @@
// Per-request state update and result formatting of the safety interlock controller.
module sic_step import sic_pkg::*; (
  input  cfg_t    cfg,
  input  item_t   item,
  input  state_t  cur,
  output state_t  nxt,
  output result_t res
);

  logic sensor_err;
  logic manual;

  assign sensor_err = !item.climate_ok || !item.meter_ok;
  assign manual     = !cur.mode_auto;

  // Apply one sample or one command to the current state.
  always_comb begin
    nxt = cur;
    if (item.operation == OP_SAMPLE) begin
      // A failed meter read keeps the previous power and current.
      if (item.meter_ok) begin
        nxt.held_current = item.current_ma;
        nxt.held_power   = item.power_dw;
      end
      nxt.unsafe_flag = 1'b0;
      if (sensor_err) begin
        // A sensor error only takes the latch when no other alarm is held.
        if (cur.alarm_latch == ALARM_NONE) begin
          nxt.alarm_latch = ALARM_SENSOR;
        end
      end else begin
        if (item.gas_level > cfg.gas_limit) begin
          nxt.unsafe_flag = 1'b1;
          nxt.alarm_latch = ALARM_GAS;
        end else if (nxt.held_power > cfg.power_limit ||
                     nxt.held_current > cfg.current_limit) begin
          nxt.unsafe_flag = 1'b1;
          nxt.alarm_latch = ALARM_OVERLOAD;
        end
        if (nxt.unsafe_flag) begin
          nxt.buzzer     = 1'b1;
          nxt.load_relay = 1'b0;
          nxt.lamp_relay = 1'b0;
        end else begin
          nxt.buzzer = 1'b0;
        end
      end
      // In auto mode the lamp follows darkness while the sample is safe.
      if (cur.mode_auto && !nxt.unsafe_flag) begin
        nxt.lamp_relay = (item.light_level < cfg.light_limit);
      end
    end else begin
      case (item.command)
        CMD_AUTO:   nxt.mode_auto = 1'b1;
        CMD_MANUAL: nxt.mode_auto = 1'b0;
        CMD_R1_ON: begin
          if (manual) nxt.load_relay = 1'b1;
        end
        CMD_R1_OFF: begin
          if (manual) nxt.load_relay = 1'b0;
        end
        CMD_R2_ON: begin
          if (manual) nxt.lamp_relay = 1'b1;
        end
        CMD_R2_OFF: begin
          if (manual) nxt.lamp_relay = 1'b0;
        end
        CMD_BUZZER_OFF: begin
          if (!cur.unsafe_flag) nxt.buzzer = 1'b0;
        end
        CMD_RESET_ALARM: begin
          if (!cur.unsafe_flag) nxt.alarm_latch = ALARM_NONE;
        end
        default: ;
      endcase
    end
  end

  // Result fields follow the updated state; pins apply the relay polarity.
  always_comb begin
    res.load_on    = nxt.load_relay;
    res.lamp_on    = nxt.lamp_relay;
    res.load_pin   = ~(nxt.load_relay ^ cfg.relay_active_high);
    res.lamp_pin   = ~(nxt.lamp_relay ^ cfg.relay_active_high);
    res.buzzer_on  = nxt.buzzer;
    res.alarm_code = nxt.alarm_latch;
    res.auto_mode  = nxt.mode_auto;
    res.danger     = nxt.unsafe_flag;
  end

endmodule

@@ rtl/safety_interlock_controller.sv @@
// Top level of the safety interlock controller: request and result registers, state.
// Each accepted request (a sensor sample or a decoded command) yields exactly one
// result. The accepting clock edge loads the request register; from there the request
// passes through the combinational state update into the result register, which
// offers the result. A new request can be accepted every cycle while item_stall is
// low; throughput is then one request per cycle. The result register frees the
// input side while a finished result waits, and item_stall rises only when both
// registers are full and result_stall is high. Configuration writes (cfg_ready is
// always high) should be made while no request is in flight.
module safety_interlock_controller import sic_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  // Configuration write channel.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // Request channel.
  input  logic                   item_valid,
  output logic                   item_stall,
  input  logic                   operation,
  input  logic [3:0]             command,
  input  logic                   climate_ok,
  input  logic                   meter_ok,
  input  logic [11:0]            gas_level,
  input  logic [11:0]            light_level,
  input  logic [16:0]            current_ma,
  input  logic [17:0]            power_dw,
  // Result channel.
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic                   load_on,
  output logic                   lamp_on,
  output logic                   load_pin,
  output logic                   lamp_pin,
  output logic                   buzzer_on,
  output logic [1:0]             alarm_code,
  output logic                   auto_mode,
  output logic                   danger
);

  cfg_t    cfg;
  item_t   item_reg;
  logic    item_reg_valid;
  logic    item_move;
  logic    item_take;
  state_t  state;
  state_t  state_next;
  result_t step_res;
  result_t res_reg;

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  sic_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Handshake: the request register drains whenever the result register can load.
  assign item_move  = item_reg_valid && (!result_valid || !result_stall);
  assign item_stall = item_reg_valid && !item_move;
  assign item_take  = item_valid && !item_stall;

  // Request register.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_reg_valid <= 1'b0;
    end else if (item_take) begin
      item_reg_valid <= 1'b1;
    end else if (item_move) begin
      item_reg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      item_reg.operation   <= operation;
      item_reg.command     <= command;
      item_reg.climate_ok  <= climate_ok;
      item_reg.meter_ok    <= meter_ok;
      item_reg.gas_level   <= gas_level;
      item_reg.light_level <= light_level;
      item_reg.current_ma  <= current_ma;
      item_reg.power_dw    <= power_dw;
    end
  end

  // State update for the request in the request register.
  sic_step u_step (
    .cfg  (cfg),
    .item (item_reg),
    .cur  (state),
    .nxt  (state_next),
    .res  (step_res)
  );

  // Controller state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode_auto    <= 1'b1;
      state.alarm_latch  <= ALARM_NONE;
      state.unsafe_flag  <= 1'b0;
      state.load_relay   <= 1'b0;
      state.lamp_relay   <= 1'b0;
      state.buzzer       <= 1'b0;
      state.held_power   <= '0;
      state.held_current <= '0;
    end else if (item_move) begin
      state <= state_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (item_move) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_move) begin
      res_reg <= step_res;
    end
  end

  assign load_on    = res_reg.load_on;
  assign lamp_on    = res_reg.lamp_on;
  assign load_pin   = res_reg.load_pin;
  assign lamp_pin   = res_reg.lamp_pin;
  assign buzzer_on  = res_reg.buzzer_on;
  assign alarm_code = res_reg.alarm_code;
  assign auto_mode  = res_reg.auto_mode;
  assign danger     = res_reg.danger;

`ifndef SYNTHESIS
  // An unsafe state always keeps the buzzer sounding.
  assert property (@(posedge clk) disable iff (rst) state.unsafe_flag |-> state.buzzer)
    else $error("unsafe state without buzzer");

  // An unsafe state always holds a gas or overload alarm.
  assert property (@(posedge clk) disable iff (rst)
    state.unsafe_flag |-> (state.alarm_latch == ALARM_GAS ||
                           state.alarm_latch == ALARM_OVERLOAD))
    else $error("unsafe state without gas or overload alarm");

  // An accepted request always lands in the request register.
  assert property (@(posedge clk) disable iff (rst) item_take |=> item_reg_valid)
    else $error("accepted request lost");
`endif

endmodule

@@ tb/sv/safety_interlock_controller_test.sv @@
// Self-checking testbench for the safety interlock controller.
`timescale 1ns / 100ps

module safety_interlock_controller_test;
  import sic_pkg::*;

  // Command codes the block ignores.
  localparam logic [3:0] CMD_FIRST_UNUSED = 4'd8;
  localparam logic [3:0] CMD_LAST_UNUSED = 4'd15;

  // First register index that has no register behind it.
  localparam logic [CFG_INDEX_W-1:0] REG_FIRST_SPARE = 3'd5;

  // Receiver stall styles.
  localparam int STALL_NONE = 0;
  localparam int STALL_RANDOM = 1;
  localparam int STALL_BURSTY = 2;
  localparam int STALL_HEAVY = 3;

  localparam int LONG_HOLD_CYCLES = 300;
  localparam int ITEMS_PER_PHASE = 240;

  // Tracks the controller state and the outputs still owed by the block.
  class interlock_tracker;
    cfg_t limits;
    state_t ctl;
    result_t awaited[$];
    int mismatches;
    int checked;
    int sample_count;
    int command_count;
    int danger_count;

    function new();
      limits.gas_limit = GAS_LIMIT_RST;
      limits.light_limit = LIGHT_LIMIT_RST;
      limits.power_limit = POWER_LIMIT_RST;
      limits.current_limit = CURRENT_LIMIT_RST;
      limits.relay_active_high = 1'b0;
      ctl = '0;
      ctl.mode_auto = 1'b1;
      mismatches = 0;
      checked = 0;
      sample_count = 0;
      command_count = 0;
      danger_count = 0;
    endfunction

    function void set_register(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      case (index)
        REG_GAS_LIMIT: limits.gas_limit = data[11:0];
        REG_LIGHT_LIMIT: limits.light_limit = data[11:0];
        REG_POWER_LIMIT: limits.power_limit = data[17:0];
        REG_CURRENT_LIMIT: limits.current_limit = data[16:0];
        REG_RELAY_ACTIVE_HIGH: limits.relay_active_high = data[0];
        default: ;
      endcase
    endfunction

    // Apply one accepted request to the state and queue the outputs it produces.
    function void note_request(item_t r);
      result_t out;
      logic read_failed;
      logic manual;
      if (r.operation == OP_SAMPLE) begin
        sample_count++;
        read_failed = !r.climate_ok || !r.meter_ok;
        if (r.meter_ok) begin
          ctl.held_current = r.current_ma;
          ctl.held_power = r.power_dw;
        end
        ctl.unsafe_flag = 1'b0;
        if (read_failed) begin
          // A failed read only marks the alarm if nothing else is latched.
          if (ctl.alarm_latch == ALARM_NONE) ctl.alarm_latch = ALARM_SENSOR;
        end else begin
          if (r.gas_level > limits.gas_limit) begin
            ctl.unsafe_flag = 1'b1;
            ctl.alarm_latch = ALARM_GAS;
          end else if (ctl.held_power > limits.power_limit ||
                       ctl.held_current > limits.current_limit) begin
            ctl.unsafe_flag = 1'b1;
            ctl.alarm_latch = ALARM_OVERLOAD;
          end
          if (ctl.unsafe_flag) begin
            ctl.buzzer = 1'b1;
            ctl.load_relay = 1'b0;
            ctl.lamp_relay = 1'b0;
          end else begin
            ctl.buzzer = 1'b0;
          end
        end
        // The lamp follows darkness in auto mode unless the sample was unsafe.
        if (ctl.mode_auto && !ctl.unsafe_flag)
          ctl.lamp_relay = (r.light_level < limits.light_limit);
      end else begin
        command_count++;
        manual = !ctl.mode_auto;
        case (r.command)
          CMD_AUTO: ctl.mode_auto = 1'b1;
          CMD_MANUAL: ctl.mode_auto = 1'b0;
          CMD_R1_ON: if (manual) ctl.load_relay = 1'b1;
          CMD_R1_OFF: if (manual) ctl.load_relay = 1'b0;
          CMD_R2_ON: if (manual) ctl.lamp_relay = 1'b1;
          CMD_R2_OFF: if (manual) ctl.lamp_relay = 1'b0;
          CMD_BUZZER_OFF: if (!ctl.unsafe_flag) ctl.buzzer = 1'b0;
          CMD_RESET_ALARM: if (!ctl.unsafe_flag) ctl.alarm_latch = ALARM_NONE;
          default: ;
        endcase
      end
      out.load_on = ctl.load_relay;
      out.lamp_on = ctl.lamp_relay;
      out.load_pin = ~(ctl.load_relay ^ limits.relay_active_high);
      out.lamp_pin = ~(ctl.lamp_relay ^ limits.relay_active_high);
      out.buzzer_on = ctl.buzzer;
      out.alarm_code = ctl.alarm_latch;
      out.auto_mode = ctl.mode_auto;
      out.danger = ctl.unsafe_flag;
      if (ctl.unsafe_flag) danger_count++;
      awaited.push_back(out);
    endfunction

    function void compare_field(string field, logic [1:0] want, logic [1:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        mismatches++;
      end
    endfunction

    // Compare one delivered result with the oldest pending one.
    function void check_outputs(result_t got);
      result_t want;
      if (awaited.size() == 0) begin
        $error("result delivered with no request outstanding");
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      checked++;
      compare_field("load_on", 2'(want.load_on), 2'(got.load_on));
      compare_field("lamp_on", 2'(want.lamp_on), 2'(got.lamp_on));
      compare_field("load_pin", 2'(want.load_pin), 2'(got.load_pin));
      compare_field("lamp_pin", 2'(want.lamp_pin), 2'(got.lamp_pin));
      compare_field("buzzer_on", 2'(want.buzzer_on), 2'(got.buzzer_on));
      compare_field("alarm_code", want.alarm_code, got.alarm_code);
      compare_field("auto_mode", 2'(want.auto_mode), 2'(got.auto_mode));
      compare_field("danger", 2'(want.danger), 2'(got.danger));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic item_valid = 1'b0;
  logic item_stall;
  logic operation = OP_SAMPLE;
  logic [3:0] command = CMD_AUTO;
  logic climate_ok = 1'b1;
  logic meter_ok = 1'b1;
  logic [11:0] gas_level = '0;
  logic [11:0] light_level = '0;
  logic [16:0] current_ma = '0;
  logic [17:0] power_dw = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic load_on;
  logic lamp_on;
  logic load_pin;
  logic lamp_pin;
  logic buzzer_on;
  logic [1:0] alarm_code;
  logic auto_mode;
  logic danger;

  interlock_tracker tracker = new();
  int stall_style = STALL_RANDOM;
  int long_holds_asked = 0;
  int settings_count = 1;

  safety_interlock_controller u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .operation(operation),
    .command(command),
    .climate_ok(climate_ok),
    .meter_ok(meter_ok),
    .gas_level(gas_level),
    .light_level(light_level),
    .current_ma(current_ma),
    .power_dw(power_dw),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .load_on(load_on),
    .lamp_on(lamp_on),
    .load_pin(load_pin),
    .lamp_pin(lamp_pin),
    .buzzer_on(buzzer_on),
    .alarm_code(alarm_code),
    .auto_mode(auto_mode),
    .danger(danger)
  );

  always #2 clk = ~clk;

  // Check every result the receiver takes.
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall)
      tracker.check_outputs({load_on, lamp_on, load_pin, lamp_pin, buzzer_on,
                             alarm_code, auto_mode, danger});
  end

  // Receiver: stalls in the current style, or holds off for a long stretch on request.
  initial begin : receiver
    int hold_left;
    int holds_seen;
    int run_left;
    logic level;
    hold_left = 0;
    holds_seen = 0;
    run_left = 0;
    level = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_seen != long_holds_asked) begin
        holds_seen = long_holds_asked;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        level = 1'b1;
      end else begin
        case (stall_style)
          STALL_NONE: level = 1'b0;
          STALL_RANDOM: level = ($urandom_range(0, 3) == 0);
          STALL_BURSTY: begin
            if (run_left == 0) begin
              level = !level;
              run_left = level ? $urandom_range(1, 5) : $urandom_range(1, 8);
            end
            run_left--;
          end
          default: level = ($urandom_range(0, 9) < 7);
        endcase
      end
      result_stall <= level;
    end
  end

  // Build a sensor sample request.
  function automatic item_t sample_req(int climate, int meter, int gas, int light,
                                       int cur, int pwr);
    item_t r;
    r = '0;
    r.operation = OP_SAMPLE;
    r.climate_ok = 1'(climate);
    r.meter_ok = 1'(meter);
    r.gas_level = 12'(gas);
    r.light_level = 12'(light);
    r.current_ma = 17'(cur);
    r.power_dw = 18'(pwr);
    return r;
  endfunction

  // Build a command request; sample fields carry random noise.
  function automatic item_t command_req(logic [3:0] code);
    item_t r;
    r = sample_req($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 4095),
                   $urandom_range(0, 4095), $urandom_range(0, 100000),
                   $urandom_range(0, 230000));
    r.operation = OP_COMMAND;
    r.command = code;
    return r;
  endfunction

  // Mostly at or below a threshold, sometimes right around it, sometimes anywhere.
  function automatic int pick_level(int lim, int top);
    int v;
    case ($urandom_range(0, 9))
      7: v = lim + $urandom_range(0, 2) - 1;
      8, 9: v = $urandom_range(0, top);
      default: v = $urandom_range(0, lim);
    endcase
    if (v < 0) v = 0;
    if (v > top) v = top;
    return v;
  endfunction

  function automatic item_t random_request();
    item_t r;
    if ($urandom_range(0, 9) < 4) begin
      r = command_req(($urandom_range(0, 9) == 0) ? 4'($urandom_range(8, 15))
                                                  : 4'($urandom_range(0, 7)));
    end else begin
      r = sample_req(int'($urandom_range(0, 11) != 0), int'($urandom_range(0, 11) != 0),
                     pick_level(int'(tracker.limits.gas_limit), 4095),
                     pick_level(int'(tracker.limits.light_limit), 4095),
                     pick_level(int'(tracker.limits.current_limit), 100000),
                     pick_level(int'(tracker.limits.power_limit), 230000));
      r.command = 4'($urandom_range(0, 15));
    end
    return r;
  endfunction

  // Present one request from a falling edge until it is accepted.
  task automatic offer_request(item_t r);
    item_valid <= 1'b1;
    operation <= r.operation;
    command <= r.command;
    climate_ok <= r.climate_ok;
    meter_ok <= r.meter_ok;
    gas_level <= r.gas_level;
    light_level <= r.light_level;
    current_ma <= r.current_ma;
    power_dw <= r.power_dw;
    do @(posedge clk); while (item_stall);
    tracker.note_request(r);
    @(negedge clk);
  endtask

  task automatic idle_sender(int cycles);
    item_valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Stop sending and wait until every pending result has been delivered.
  task automatic drain_results();
    item_valid <= 1'b0;
    do @(negedge clk); while (tracker.awaited.size() != 0);
  endtask

  task automatic write_register(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_register(index, data);
    @(negedge clk);
  endtask

  // Reprogram all registers while the block is idle, plus one write to a spare index.
  task automatic apply_settings(logic [CFG_DATA_W-1:0] gas, logic [CFG_DATA_W-1:0] light,
                                logic [CFG_DATA_W-1:0] pwr, logic [CFG_DATA_W-1:0] cur,
                                logic polarity);
    drain_results();
    repeat (2) @(negedge clk);
    write_register(REG_GAS_LIMIT, gas);
    write_register(REG_LIGHT_LIMIT, light);
    write_register(REG_POWER_LIMIT, pwr);
    write_register(REG_CURRENT_LIMIT, cur);
    write_register(REG_RELAY_ACTIVE_HIGH, {17'($urandom), polarity});
    write_register(3'(REG_FIRST_SPARE + $urandom_range(0, 2)), 18'($urandom));
    cfg_valid <= 1'b0;
    @(negedge clk);
    settings_count++;
  endtask

  // Random requests in bursts; halfway through the sender waits for the block to empty.
  task automatic run_random(int count, int style, bit with_gaps);
    int burst_left;
    burst_left = 0;
    stall_style = style;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) drain_results();
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        if (with_gaps && $urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 6));
      end
      offer_request(random_request());
      burst_left--;
    end
  endtask

  // Overall run limit.
  initial begin : watchdog
    #2000000;
    $display("safety_interlock_controller_test NOT OK");
    $finish;
  end

  initial begin : stimulus
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed requests at reset thresholds: boundaries, alarms, read failures, commands.
    offer_request(sample_req(1, 1, 0, 0, 0, 0));
    offer_request(sample_req(1, 1, 250, 2000, 2000, 5000));
    offer_request(sample_req(1, 1, 251, 1999, 0, 0));
    offer_request(command_req(CMD_BUZZER_OFF));
    offer_request(command_req(CMD_RESET_ALARM));
    offer_request(command_req(CMD_R1_ON));
    offer_request(sample_req(1, 1, 4095, 4095, 100000, 230000));
    offer_request(sample_req(1, 1, 0, 4095, 0, 5001));
    offer_request(sample_req(1, 1, 0, 0, 2001, 0));
    offer_request(sample_req(1, 0, 4095, 0, 100000, 230000));
    offer_request(command_req(CMD_BUZZER_OFF));
    offer_request(command_req(CMD_RESET_ALARM));
    offer_request(sample_req(0, 1, 4095, 4095, 100000, 230000));
    offer_request(command_req(CMD_MANUAL));
    offer_request(command_req(CMD_R1_ON));
    offer_request(command_req(CMD_R2_ON));
    offer_request(sample_req(1, 1, 0, 0, 0, 0));
    offer_request(sample_req(1, 1, 300, 0, 0, 0));
    offer_request(command_req(CMD_R1_ON));
    offer_request(command_req(CMD_R2_ON));
    offer_request(command_req(CMD_R1_OFF));
    offer_request(command_req(CMD_R2_OFF));
    offer_request(command_req(CMD_FIRST_UNUSED));
    offer_request(command_req(CMD_LAST_UNUSED));
    offer_request(command_req(CMD_AUTO));
    offer_request(command_req(CMD_RESET_ALARM));

    // A random phase at reset thresholds.
    run_random(ITEMS_PER_PHASE, STALL_RANDOM, 1'b1);

    // All thresholds at zero, active-high relays; the receiver holds off early on.
    apply_settings(18'd0, 18'd0, 18'd0, 18'd0, 1'b1);
    long_holds_asked++;
    run_random(ITEMS_PER_PHASE, STALL_BURSTY, 1'b1);

    // Top of every range; the over-width writes must be cut to the register width.
    apply_settings(18'h3FFFF, 18'h3FFFF, 18'd230000, 18'd100000, 1'b0);
    run_random(ITEMS_PER_PHASE, STALL_HEAVY, 1'b1);

    // Random thresholds with a back-to-back stretch and no stalls.
    apply_settings(18'($urandom_range(0, 4095)), 18'($urandom_range(0, 4095)),
                   18'($urandom_range(0, 230000)), 18'($urandom_range(0, 100000)),
                   1'($urandom_range(0, 1)));
    run_random(ITEMS_PER_PHASE, STALL_NONE, 1'b0);

    // Back to the reset thresholds.
    apply_settings(18'(GAS_LIMIT_RST), 18'(LIGHT_LIMIT_RST), POWER_LIMIT_RST,
                   18'(CURRENT_LIMIT_RST), 1'b0);
    run_random(ITEMS_PER_PHASE, STALL_BURSTY, 1'b1);

    drain_results();
    repeat (8) @(posedge clk);
    $display("Ran %0d samples and %0d commands under %0d register settings.",
             tracker.sample_count, tracker.command_count, settings_count);
    $display("Checked %0d results, %0d of them flagging danger.",
             tracker.checked, tracker.danger_count);
    if (tracker.mismatches == 0 && tracker.awaited.size() == 0) begin
      $display("safety_interlock_controller_test OK");
    end else begin
      $display("safety_interlock_controller_test NOT OK");
    end
    $finish;
  end

endmodule
